FILE: src/rcm_pkg.sv
package rcm_pkg;

    localparam int US_W      = 11;
    localparam int PCT_W     = 7;
    localparam int STICK_W   = 11;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 11;

    // datapath widths, sized to the worst-case magnitudes of each step
    localparam int LANES   = 2;
    localparam int T_W     = 18;   // stick or side times a percent, signed
    localparam int MAG_W   = T_W - 1;
    localparam int RECIP_K = 41943;    // floor(2^22 / 100)
    localparam int RECIP_S = 22;
    localparam int K_W     = 16;
    localparam int PROD_W  = MAG_W + K_W;
    localparam int Q_W     = 11;   // quotient of a magnitude by 100
    localparam int RES_W   = Q_W + 1;
    localparam int SIDE_W  = 13;   // throttle plus or minus scaled steer
    localparam int ABS_W   = SIDE_W - 1;
    localparam int NUM_W   = 22;   // side magnitude times 1000
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W   = $clog2(DIV_STEPS);

    localparam int SPEED_HIGH_US = 1700;
    localparam int SPEED_MID_US  = 1300;
    localparam int PEAK_LIMIT    = 1000;
    localparam int PCT_SCALE     = 100;

    localparam logic [US_W-1:0]  AUTO_THR_RST   = 11'd1500;
    localparam logic [US_W-1:0]  LASER_THR_RST  = 11'd1700;
    localparam logic [US_W-1:0]  ESTOP_THR_RST  = 11'd1500;
    localparam logic [US_W-1:0]  FIRE_THR_RST   = 11'd1700;
    localparam logic [PCT_W-1:0] TURN_GAIN_RST  = 7'd60;
    localparam logic [PCT_W-1:0] SPEED_LOW_RST  = 7'd30;
    localparam logic [PCT_W-1:0] SPEED_MID_RST  = 7'd60;
    localparam logic [PCT_W-1:0] SPEED_HIGH_RST = 7'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AUTO_THR   = 3'd0,
        CFG_LASER_THR  = 3'd1,
        CFG_ESTOP_THR  = 3'd2,
        CFG_FIRE_THR   = 3'd3,
        CFG_TURN_GAIN  = 3'd4,
        CFG_SPEED_LOW  = 3'd5,
        CFG_SPEED_MID  = 3'd6,
        CFG_SPEED_HIGH = 3'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_GAIN,
        OP_RECIP,
        OP_QUOT,
        OP_MIX,
        OP_PREP,
        OP_DIV_STEP,
        OP_FIX,
        OP_PCT,
        OP_OUT
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAIN,
        ST_RECIP_S,
        ST_QUOT_S,
        ST_MIX,
        ST_PREP,
        ST_DIV,
        ST_FIX,
        ST_PCT,
        ST_RECIP_P,
        ST_QUOT_P,
        ST_OUT
    } state_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic over;
        logic div_last;
    } dp_status_t;

endpackage

FILE: src/rcm_ctrl.sv
module rcm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  rcm_pkg::dp_status_t status,
    output rcm_pkg::dp_cmd_t    cmd
);

    rcm_pkg::state_t state_reg;
    rcm_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rcm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rcm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = rcm_pkg::ST_GAIN;
                end
            end
            rcm_pkg::ST_GAIN:    state_next = rcm_pkg::ST_RECIP_S;
            rcm_pkg::ST_RECIP_S: state_next = rcm_pkg::ST_QUOT_S;
            rcm_pkg::ST_QUOT_S:  state_next = rcm_pkg::ST_MIX;
            rcm_pkg::ST_MIX:     state_next = rcm_pkg::ST_PREP;
            rcm_pkg::ST_PREP:
            begin
                // peak scaling only when a side exceeds the limit in drive
                state_next = status.over ? rcm_pkg::ST_DIV : rcm_pkg::ST_PCT;
            end
            rcm_pkg::ST_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = rcm_pkg::ST_FIX;
                end
            end
            rcm_pkg::ST_FIX:     state_next = rcm_pkg::ST_PCT;
            rcm_pkg::ST_PCT:     state_next = rcm_pkg::ST_RECIP_P;
            rcm_pkg::ST_RECIP_P: state_next = rcm_pkg::ST_QUOT_P;
            rcm_pkg::ST_QUOT_P:  state_next = rcm_pkg::ST_OUT;
            rcm_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = rcm_pkg::ST_IDLE;
                end
            end
            default:             state_next = rcm_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd.op   = rcm_pkg::OP_NONE;
        case (state_reg)
            rcm_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = rcm_pkg::OP_LOAD;
                end
            end
            rcm_pkg::ST_GAIN:    cmd.op = rcm_pkg::OP_GAIN;
            rcm_pkg::ST_RECIP_S: cmd.op = rcm_pkg::OP_RECIP;
            rcm_pkg::ST_QUOT_S:  cmd.op = rcm_pkg::OP_QUOT;
            rcm_pkg::ST_MIX:     cmd.op = rcm_pkg::OP_MIX;
            rcm_pkg::ST_PREP:    cmd.op = rcm_pkg::OP_PREP;
            rcm_pkg::ST_DIV:     cmd.op = rcm_pkg::OP_DIV_STEP;
            rcm_pkg::ST_FIX:     cmd.op = rcm_pkg::OP_FIX;
            rcm_pkg::ST_PCT:     cmd.op = rcm_pkg::OP_PCT;
            rcm_pkg::ST_RECIP_P: cmd.op = rcm_pkg::OP_RECIP;
            rcm_pkg::ST_QUOT_P:  cmd.op = rcm_pkg::OP_QUOT;
            rcm_pkg::ST_OUT:
            begin
                // hold until the previous result has been transferred
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op = rcm_pkg::OP_OUT;
                end
            end
            default:             cmd.op = rcm_pkg::OP_NONE;
        endcase
    end

    always_comb
    begin
        if (cmd.op == rcm_pkg::OP_OUT)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: src/rcm_dp.sv
module rcm_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rcm_pkg::dp_cmd_t                     cmd,
    output rcm_pkg::dp_status_t                  status,
    input  logic                                 cfg_valid,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rcm_pkg::CFG_DAT_W-1:0]        cfg_data,
    input  logic                                 link_ok,
    input  logic [rcm_pkg::US_W-1:0]             estop_channel_us,
    input  logic [rcm_pkg::US_W-1:0]             laser_channel_us,
    input  logic [rcm_pkg::US_W-1:0]             mode_channel_us,
    input  logic [rcm_pkg::US_W-1:0]             speed_channel_us,
    input  logic [rcm_pkg::US_W-1:0]             fire_channel_us,
    input  logic signed [rcm_pkg::STICK_W-1:0]   throttle_norm,
    input  logic signed [rcm_pkg::STICK_W-1:0]   steer_norm,
    output logic signed [rcm_pkg::STICK_W-1:0]   left_speed,
    output logic signed [rcm_pkg::STICK_W-1:0]   right_speed,
    output logic                                 motor_enable,
    output logic                                 fire_out,
    output logic                                 laser_active,
    output logic                                 auto_active,
    output logic                                 estop_latched
);

    localparam int L = rcm_pkg::LANES;
    localparam int MUL_W = rcm_pkg::T_W + 1;

    // configuration and tick state
    logic [rcm_pkg::US_W-1:0]  auto_thr_reg, laser_thr_reg, estop_thr_reg, fire_thr_reg;
    logic [rcm_pkg::US_W-1:0]  auto_thr_next, laser_thr_next, estop_thr_next, fire_thr_next;
    logic [rcm_pkg::PCT_W-1:0] gain_reg, spd_low_reg, spd_mid_reg, spd_high_reg;
    logic [rcm_pkg::PCT_W-1:0] gain_next, spd_low_next, spd_mid_next, spd_high_next;
    logic latch_reg, latch_next, before_reg, before_next;

    // per-tick payload
    logic drive_reg, drive_next, laser_reg, laser_next;
    logic autom_reg, autom_next, fire_reg, fire_next;
    logic [rcm_pkg::PCT_W-1:0]          pct_reg, pct_next;
    logic signed [rcm_pkg::STICK_W-1:0] thr_reg, thr_next, str_reg, str_next;

    logic signed [rcm_pkg::T_W-1:0]    t_reg [L];
    logic signed [rcm_pkg::T_W-1:0]    t_next [L];
    logic [rcm_pkg::MAG_W-1:0]         mag_reg [L];
    logic [rcm_pkg::MAG_W-1:0]         mag_next [L];
    logic                              sgn_reg [L];
    logic                              sgn_next [L];
    logic [rcm_pkg::PROD_W-1:0]        prod_reg [L];
    logic [rcm_pkg::PROD_W-1:0]        prod_next [L];
    logic signed [rcm_pkg::RES_W-1:0]  res_reg [L];
    logic signed [rcm_pkg::RES_W-1:0]  res_next [L];
    logic signed [rcm_pkg::SIDE_W-1:0] side_reg [L];
    logic signed [rcm_pkg::SIDE_W-1:0] side_next [L];
    logic [rcm_pkg::NUM_W-1:0]         num_reg [L];
    logic [rcm_pkg::NUM_W-1:0]         num_next [L];
    logic [rcm_pkg::ABS_W-1:0]         rem_reg [L];
    logic [rcm_pkg::ABS_W-1:0]         rem_next [L];
    logic [rcm_pkg::ABS_W-1:0]         peak_reg, peak_next;
    logic                              over_reg, over_next;
    logic [rcm_pkg::CNT_W-1:0]         cnt_reg, cnt_next;

    logic signed [rcm_pkg::STICK_W-1:0] left_reg, left_next, right_reg, right_next;
    logic enable_reg, enable_next, fire_o_reg, fire_o_next;
    logic laser_o_reg, laser_o_next, auto_o_reg, auto_o_next, latch_o_reg, latch_o_next;

    // tick decisions
    logic btn, laser_sel, auto_on, latch_upd, latch_new;

    // lane arithmetic
    logic signed [MUL_W-1:0]           str_ext, gain_ext, gain_prod, pct_ext;
    logic signed [MUL_W-1:0]           pct_prod [L];
    logic signed [rcm_pkg::T_W-1:0]    t_neg [L];
    logic [rcm_pkg::MAG_W-1:0]         mag_w [L];
    logic [rcm_pkg::Q_W-1:0]           q0 [L];
    logic [rcm_pkg::Q_W-1:0]           q_fix [L];
    logic [rcm_pkg::MAG_W-1:0]         q0x100 [L];
    logic [rcm_pkg::MAG_W-1:0]         r_w [L];
    logic signed [rcm_pkg::SIDE_W-1:0] mix_w [L];
    logic [rcm_pkg::ABS_W-1:0]         mix_abs [L];
    logic [rcm_pkg::ABS_W-1:0]         side_abs [L];
    logic signed [rcm_pkg::SIDE_W-1:0] res_ext, thr_ext;
    logic [rcm_pkg::ABS_W:0]           trial [L];
    logic                              trial_ge [L];
    logic signed [rcm_pkg::STICK_W-1:0] sat_w [L];

    function automatic logic [rcm_pkg::ABS_W-1:0] abs_side(
        input logic signed [rcm_pkg::SIDE_W-1:0] v
    );
        logic signed [rcm_pkg::SIDE_W-1:0] n;
        n = -v;
        return v[rcm_pkg::SIDE_W-1] ? n[rcm_pkg::ABS_W-1:0] : v[rcm_pkg::ABS_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // mode and latch decisions for the incoming tick
    assign btn       = estop_channel_us > estop_thr_reg;
    assign laser_sel = laser_channel_us > laser_thr_reg;
    assign auto_on   = mode_channel_us > auto_thr_reg;
    // set on a button rising edge, release only with button up in manual
    assign latch_upd = (latch_reg | (btn & ~before_reg)) & (btn | auto_on);
    assign latch_new = link_ok ? latch_upd : latch_reg;

    // ------------------------------------------------------------------
    assign str_ext   = {{(MUL_W-rcm_pkg::STICK_W){str_reg[rcm_pkg::STICK_W-1]}}, str_reg};
    assign gain_ext  = {{(MUL_W-rcm_pkg::PCT_W){1'b0}}, gain_reg};
    assign gain_prod = str_ext * gain_ext;
    assign pct_ext   = {{(MUL_W-rcm_pkg::PCT_W){1'b0}}, pct_reg};
    assign res_ext   = {{(rcm_pkg::SIDE_W-rcm_pkg::RES_W){res_reg[0][rcm_pkg::RES_W-1]}},
                        res_reg[0]};
    assign thr_ext   = {{(rcm_pkg::SIDE_W-rcm_pkg::STICK_W){thr_reg[rcm_pkg::STICK_W-1]}},
                        thr_reg};
    assign mix_w[0]  = thr_ext + res_ext;
    assign mix_w[1]  = thr_ext - res_ext;

    always_comb
    begin
        for (int i = 0; i < L; i++)
        begin
            // magnitude for the divide-by-100 reciprocal
            t_neg[i] = -t_reg[i];
            mag_w[i] = t_reg[i][rcm_pkg::T_W-1] ? t_neg[i][rcm_pkg::MAG_W-1:0]
                                                : t_reg[i][rcm_pkg::MAG_W-1:0];
            // reciprocal estimate is low by at most one; fix with one compare
            q0[i]     = prod_reg[i][rcm_pkg::RECIP_S +: rcm_pkg::Q_W];
            q0x100[i] = rcm_pkg::MAG_W'(q0[i]) * rcm_pkg::MAG_W'(rcm_pkg::PCT_SCALE);
            r_w[i]    = mag_reg[i] - q0x100[i];
            q_fix[i]  = (r_w[i] >= rcm_pkg::MAG_W'(rcm_pkg::PCT_SCALE)) ? q0[i] + 1'b1 : q0[i];

            mix_abs[i]  = abs_side(mix_w[i]);
            side_abs[i] = abs_side(side_reg[i]);

            // one restoring step of the peak divide
            trial[i]    = {rem_reg[i], num_reg[i][rcm_pkg::NUM_W-1]};
            trial_ge[i] = trial[i] >= {1'b0, peak_reg};

            pct_prod[i] = {{(MUL_W-rcm_pkg::SIDE_W){side_reg[i][rcm_pkg::SIDE_W-1]}},
                           side_reg[i]} * pct_ext;

            if (res_reg[i] > $signed(rcm_pkg::RES_W'(rcm_pkg::PEAK_LIMIT)))
            begin
                sat_w[i] = rcm_pkg::STICK_W'(rcm_pkg::PEAK_LIMIT);
            end
            else if (res_reg[i] < -$signed(rcm_pkg::RES_W'(rcm_pkg::PEAK_LIMIT)))
            begin
                sat_w[i] = -$signed(rcm_pkg::STICK_W'(rcm_pkg::PEAK_LIMIT));
            end
            else
            begin
                sat_w[i] = res_reg[i][rcm_pkg::STICK_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    always_comb
    begin
        auto_thr_next  = auto_thr_reg;
        laser_thr_next = laser_thr_reg;
        estop_thr_next = estop_thr_reg;
        fire_thr_next  = fire_thr_reg;
        gain_next      = gain_reg;
        spd_low_next   = spd_low_reg;
        spd_mid_next   = spd_mid_reg;
        spd_high_next  = spd_high_reg;
        if (cfg_valid)
        begin
            case (rcm_pkg::cfg_idx_t'(cfg_index))
                rcm_pkg::CFG_AUTO_THR:   auto_thr_next  = cfg_data[rcm_pkg::US_W-1:0];
                rcm_pkg::CFG_LASER_THR:  laser_thr_next = cfg_data[rcm_pkg::US_W-1:0];
                rcm_pkg::CFG_ESTOP_THR:  estop_thr_next = cfg_data[rcm_pkg::US_W-1:0];
                rcm_pkg::CFG_FIRE_THR:   fire_thr_next  = cfg_data[rcm_pkg::US_W-1:0];
                rcm_pkg::CFG_TURN_GAIN:  gain_next      = cfg_data[rcm_pkg::PCT_W-1:0];
                rcm_pkg::CFG_SPEED_LOW:  spd_low_next   = cfg_data[rcm_pkg::PCT_W-1:0];
                rcm_pkg::CFG_SPEED_MID:  spd_mid_next   = cfg_data[rcm_pkg::PCT_W-1:0];
                rcm_pkg::CFG_SPEED_HIGH: spd_high_next  = cfg_data[rcm_pkg::PCT_W-1:0];
                default:                 gain_next      = gain_reg;
            endcase
        end
    end

    always_comb
    begin
        latch_next   = latch_reg;
        before_next  = before_reg;
        drive_next   = drive_reg;
        laser_next   = laser_reg;
        autom_next   = autom_reg;
        fire_next    = fire_reg;
        pct_next     = pct_reg;
        thr_next     = thr_reg;
        str_next     = str_reg;
        t_next       = t_reg;
        mag_next     = mag_reg;
        sgn_next     = sgn_reg;
        prod_next    = prod_reg;
        res_next     = res_reg;
        side_next    = side_reg;
        num_next     = num_reg;
        rem_next     = rem_reg;
        peak_next    = peak_reg;
        over_next    = over_reg;
        cnt_next     = cnt_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        enable_next  = enable_reg;
        fire_o_next  = fire_o_reg;
        laser_o_next = laser_o_reg;
        auto_o_next  = auto_o_reg;
        latch_o_next = latch_o_reg;

        case (cmd.op)
            rcm_pkg::OP_LOAD:
            begin
                latch_next  = latch_new;
                before_next = link_ok & btn;
                laser_next  = link_ok & laser_sel;
                autom_next  = link_ok & ~laser_sel & auto_on;
                drive_next  = link_ok & ~latch_new & ~laser_sel & ~auto_on;
                fire_next   = link_ok & ~latch_new & laser_sel & (fire_channel_us > fire_thr_reg);
                if (speed_channel_us > rcm_pkg::US_W'(rcm_pkg::SPEED_HIGH_US))
                begin
                    pct_next = spd_high_reg;
                end
                else if (speed_channel_us > rcm_pkg::US_W'(rcm_pkg::SPEED_MID_US))
                begin
                    pct_next = spd_mid_reg;
                end
                else
                begin
                    pct_next = spd_low_reg;
                end
                thr_next = throttle_norm;
                str_next = steer_norm;
            end
            rcm_pkg::OP_GAIN:
            begin
                t_next[0] = gain_prod[rcm_pkg::T_W-1:0];
                t_next[1] = '0;
            end
            rcm_pkg::OP_RECIP:
            begin
                for (int i = 0; i < L; i++)
                begin
                    mag_next[i]  = mag_w[i];
                    sgn_next[i]  = t_reg[i][rcm_pkg::T_W-1];
                    prod_next[i] = rcm_pkg::PROD_W'(mag_w[i]) *
                                   rcm_pkg::PROD_W'(rcm_pkg::RECIP_K);
                end
            end
            rcm_pkg::OP_QUOT:
            begin
                for (int i = 0; i < L; i++)
                begin
                    res_next[i] = sgn_reg[i] ? -$signed({1'b0, q_fix[i]})
                                             : $signed({1'b0, q_fix[i]});
                end
            end
            rcm_pkg::OP_MIX:
            begin
                side_next[0] = mix_w[0];
                side_next[1] = mix_w[1];
                peak_next    = (mix_abs[1] > mix_abs[0]) ? mix_abs[1] : mix_abs[0];
                over_next    = drive_reg &
                               (((mix_abs[1] > mix_abs[0]) ? mix_abs[1] : mix_abs[0]) >
                                rcm_pkg::ABS_W'(rcm_pkg::PEAK_LIMIT));
            end
            rcm_pkg::OP_PREP:
            begin
                for (int i = 0; i < L; i++)
                begin
                    num_next[i] = rcm_pkg::NUM_W'(side_abs[i]) *
                                  rcm_pkg::NUM_W'(rcm_pkg::PEAK_LIMIT);
                    rem_next[i] = '0;
                    sgn_next[i] = side_reg[i][rcm_pkg::SIDE_W-1];
                end
                cnt_next = '0;
            end
            rcm_pkg::OP_DIV_STEP:
            begin
                for (int i = 0; i < L; i++)
                begin
                    rem_next[i] = trial_ge[i] ? rcm_pkg::ABS_W'(trial[i] - {1'b0, peak_reg})
                                              : trial[i][rcm_pkg::ABS_W-1:0];
                    num_next[i] = {num_reg[i][rcm_pkg::NUM_W-2:0], trial_ge[i]};
                end
                cnt_next = cnt_reg + 1'b1;
            end
            rcm_pkg::OP_FIX:
            begin
                for (int i = 0; i < L; i++)
                begin
                    side_next[i] = sgn_reg[i]
                        ? -$signed(rcm_pkg::SIDE_W'(num_reg[i][rcm_pkg::Q_W-1:0]))
                        : $signed(rcm_pkg::SIDE_W'(num_reg[i][rcm_pkg::Q_W-1:0]));
                end
            end
            rcm_pkg::OP_PCT:
            begin
                for (int i = 0; i < L; i++)
                begin
                    t_next[i] = pct_prod[i][rcm_pkg::T_W-1:0];
                end
            end
            rcm_pkg::OP_OUT:
            begin
                left_next    = drive_reg ? sat_w[0] : '0;
                right_next   = drive_reg ? sat_w[1] : '0;
                enable_next  = drive_reg;
                fire_o_next  = fire_reg;
                laser_o_next = laser_reg;
                auto_o_next  = autom_reg;
                latch_o_next = latch_reg;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_thr_reg  <= rcm_pkg::AUTO_THR_RST;
            laser_thr_reg <= rcm_pkg::LASER_THR_RST;
            estop_thr_reg <= rcm_pkg::ESTOP_THR_RST;
            fire_thr_reg  <= rcm_pkg::FIRE_THR_RST;
            gain_reg      <= rcm_pkg::TURN_GAIN_RST;
            spd_low_reg   <= rcm_pkg::SPEED_LOW_RST;
            spd_mid_reg   <= rcm_pkg::SPEED_MID_RST;
            spd_high_reg  <= rcm_pkg::SPEED_HIGH_RST;
            latch_reg     <= 1'b0;
            before_reg    <= 1'b0;
            over_reg      <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            auto_thr_reg  <= auto_thr_next;
            laser_thr_reg <= laser_thr_next;
            estop_thr_reg <= estop_thr_next;
            fire_thr_reg  <= fire_thr_next;
            gain_reg      <= gain_next;
            spd_low_reg   <= spd_low_next;
            spd_mid_reg   <= spd_mid_next;
            spd_high_reg  <= spd_high_next;
            latch_reg     <= latch_next;
            before_reg    <= before_next;
            over_reg      <= over_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drive_reg   <= drive_next;
        laser_reg   <= laser_next;
        autom_reg   <= autom_next;
        fire_reg    <= fire_next;
        pct_reg     <= pct_next;
        thr_reg     <= thr_next;
        str_reg     <= str_next;
        t_reg       <= t_next;
        mag_reg     <= mag_next;
        sgn_reg     <= sgn_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
        side_reg    <= side_next;
        num_reg     <= num_next;
        rem_reg     <= rem_next;
        peak_reg    <= peak_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        enable_reg  <= enable_next;
        fire_o_reg  <= fire_o_next;
        laser_o_reg <= laser_o_next;
        auto_o_reg  <= auto_o_next;
        latch_o_reg <= latch_o_next;
    end

    assign status.over     = over_reg;
    assign status.div_last = cnt_reg == rcm_pkg::CNT_W'(rcm_pkg::DIV_STEPS - 1);

    assign left_speed    = left_reg;
    assign right_speed   = right_reg;
    assign motor_enable  = enable_reg;
    assign fire_out      = fire_o_reg;
    assign laser_active  = laser_o_reg;
    assign auto_active   = auto_o_reg;
    assign estop_latched = latch_o_reg;

endmodule

FILE: src/rc_mode_estop_and_skid_steer_mixer_unit.sv
// Sequence: after an input transfer: gain, reciprocal, quotient, mix and prep;
//   when the mixed peak exceeds 1000 in drive, the 22-step restoring divider on both
//   sides and a fix step; then percent, reciprocal, quotient and output. One tick at
//   a time: no new tick is taken until the output step, held by an untaken result.
// Reset: asynchronous, active low; clears the stop latch and button history and
//   loads the configuration defaults. Configuration writes are taken every cycle.
module rc_mode_estop_and_skid_steer_mixer_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 link_ok,
    input  logic [rcm_pkg::US_W-1:0]             estop_channel_us,
    input  logic [rcm_pkg::US_W-1:0]             laser_channel_us,
    input  logic [rcm_pkg::US_W-1:0]             mode_channel_us,
    input  logic [rcm_pkg::US_W-1:0]             speed_channel_us,
    input  logic [rcm_pkg::US_W-1:0]             fire_channel_us,
    input  logic signed [rcm_pkg::STICK_W-1:0]   throttle_norm,
    input  logic signed [rcm_pkg::STICK_W-1:0]   steer_norm,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [rcm_pkg::STICK_W-1:0]   left_speed,
    output logic signed [rcm_pkg::STICK_W-1:0]   right_speed,
    output logic                                 motor_enable,
    output logic                                 fire_out,
    output logic                                 laser_active,
    output logic                                 auto_active,
    output logic                                 estop_latched,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [rcm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [rcm_pkg::CFG_DAT_W-1:0]        cfg_data
);

    rcm_pkg::dp_cmd_t    cmd;
    rcm_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    rcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    rcm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .link_ok          (link_ok),
        .estop_channel_us (estop_channel_us),
        .laser_channel_us (laser_channel_us),
        .mode_channel_us  (mode_channel_us),
        .speed_channel_us (speed_channel_us),
        .fire_channel_us  (fire_channel_us),
        .throttle_norm    (throttle_norm),
        .steer_norm       (steer_norm),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .motor_enable     (motor_enable),
        .fire_out         (fire_out),
        .laser_active     (laser_active),
        .auto_active      (auto_active),
        .estop_latched    (estop_latched)
    );

    // stopped tracks whenever the motors are not enabled
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !motor_enable |-> left_speed == '0 && right_speed == '0)
        else $error("speed nonzero with motors disabled");

    // manual drive excludes every other mode and the latch
    a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && motor_enable |-> !laser_active && !auto_active && !estop_latched)
        else $error("drive enabled outside manual mode");

    // fire only from laser mode with the latch clear
    a_fire_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && fire_out |-> laser_active && !estop_latched && !auto_active)
        else $error("fire outside laser mode");

    // both sides stay inside the limit
    a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> left_speed <= 11'sd1000 && left_speed >= -11'sd1000 &&
                      right_speed <= 11'sd1000 && right_speed >= -11'sd1000)
        else $error("track speed out of range");

endmodule

FILE: dv/tb_rc_mode_estop_and_skid_steer_mixer_unit.sv
module tb_rc_mode_estop_and_skid_steer_mixer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_LEN  = 400;
    localparam int QUIET_MAX = 4000;
    localparam int DRAIN_GAP = 40;

    typedef struct {
        logic                               link;
        logic [rcm_pkg::US_W-1:0]           estop;
        logic [rcm_pkg::US_W-1:0]           laser;
        logic [rcm_pkg::US_W-1:0]           mode;
        logic [rcm_pkg::US_W-1:0]           speed;
        logic [rcm_pkg::US_W-1:0]           fire;
        logic signed [rcm_pkg::STICK_W-1:0] thr;
        logic signed [rcm_pkg::STICK_W-1:0] steer;
    } tick_t;

    typedef struct {
        logic signed [rcm_pkg::STICK_W-1:0] left;
        logic signed [rcm_pkg::STICK_W-1:0] right;
        logic                               en;
        logic                               fire;
        logic                               laser;
        logic                               autom;
        logic                               latch;
    } track_cmd_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               link_ok = 1'b0;
    logic [rcm_pkg::US_W-1:0]           estop_channel_us = '0;
    logic [rcm_pkg::US_W-1:0]           laser_channel_us = '0;
    logic [rcm_pkg::US_W-1:0]           mode_channel_us = '0;
    logic [rcm_pkg::US_W-1:0]           speed_channel_us = '0;
    logic [rcm_pkg::US_W-1:0]           fire_channel_us = '0;
    logic signed [rcm_pkg::STICK_W-1:0] throttle_norm = '0;
    logic signed [rcm_pkg::STICK_W-1:0] steer_norm = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [rcm_pkg::STICK_W-1:0] left_speed;
    logic signed [rcm_pkg::STICK_W-1:0] right_speed;
    logic                               motor_enable;
    logic                               fire_out;
    logic                               laser_active;
    logic                               auto_active;
    logic                               estop_latched;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [rcm_pkg::CFG_IDX_W-1:0]      cfg_index = '0;
    logic [rcm_pkg::CFG_DAT_W-1:0]      cfg_data = '0;

    rc_mode_estop_and_skid_steer_mixer_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .link_ok          (link_ok),
        .estop_channel_us (estop_channel_us),
        .laser_channel_us (laser_channel_us),
        .mode_channel_us  (mode_channel_us),
        .speed_channel_us (speed_channel_us),
        .fire_channel_us  (fire_channel_us),
        .throttle_norm    (throttle_norm),
        .steer_norm       (steer_norm),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_speed       (left_speed),
        .right_speed      (right_speed),
        .motor_enable     (motor_enable),
        .fire_out         (fire_out),
        .laser_active     (laser_active),
        .auto_active      (auto_active),
        .estop_latched    (estop_latched),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor copy of the registers and the latch state
    logic [rcm_pkg::US_W-1:0]  auto_thr  = rcm_pkg::AUTO_THR_RST;
    logic [rcm_pkg::US_W-1:0]  laser_thr = rcm_pkg::LASER_THR_RST;
    logic [rcm_pkg::US_W-1:0]  estop_thr = rcm_pkg::ESTOP_THR_RST;
    logic [rcm_pkg::US_W-1:0]  fire_thr  = rcm_pkg::FIRE_THR_RST;
    logic [rcm_pkg::PCT_W-1:0] turn_gain = rcm_pkg::TURN_GAIN_RST;
    logic [rcm_pkg::PCT_W-1:0] lim_low   = rcm_pkg::SPEED_LOW_RST;
    logic [rcm_pkg::PCT_W-1:0] lim_mid   = rcm_pkg::SPEED_MID_RST;
    logic [rcm_pkg::PCT_W-1:0] lim_high  = rcm_pkg::SPEED_HIGH_RST;
    logic                      latch_q   = 1'b0;
    logic                      button_q  = 1'b0;

    tick_t      ticks_waiting[$];
    track_cmd_t due_cmds[$];
    tick_t      cur_tick;

    int errors = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    logic hold_req = 1'b0;
    int hold_cnt = 0;
    int quiet = 0;

    function automatic int clamp_track(int v);
        if (v > rcm_pkg::PEAK_LIMIT)
            return rcm_pkg::PEAK_LIMIT;
        if (v < -rcm_pkg::PEAK_LIMIT)
            return -rcm_pkg::PEAK_LIMIT;
        return v;
    endfunction

    function automatic track_cmd_t mix_tick(tick_t t);
        track_cmd_t o;
        logic pressed;
        logic laser_sel;
        logic auto_on;
        int pct;
        int st;
        int l;
        int r;
        int peak;
        o = '{default: '0};
        if (!t.link)
            button_q = 1'b0;
        else
        begin
            pressed   = t.estop > estop_thr;
            laser_sel = t.laser > laser_thr;
            auto_on   = t.mode > auto_thr;
            if (pressed && !button_q)
                latch_q = 1'b1;
            button_q = pressed;
            if (latch_q && !pressed && !auto_on)
                latch_q = 1'b0;
            o.laser = laser_sel;
            o.autom = !laser_sel && auto_on;
            if (!latch_q && !o.laser && !o.autom)
            begin
                o.en = 1'b1;
                if (t.speed > rcm_pkg::SPEED_HIGH_US)
                    pct = int'(lim_high);
                else if (t.speed > rcm_pkg::SPEED_MID_US)
                    pct = int'(lim_mid);
                else
                    pct = int'(lim_low);
                st = (int'(t.steer) * int'(turn_gain)) / rcm_pkg::PCT_SCALE;
                l = int'(t.thr) + st;
                r = int'(t.thr) - st;
                peak = (l < 0) ? -l : l;
                if (((r < 0) ? -r : r) > peak)
                    peak = (r < 0) ? -r : r;
                // scale both sides together so the larger one lands on the limit
                if (peak > rcm_pkg::PEAK_LIMIT)
                begin
                    l = (l * rcm_pkg::PEAK_LIMIT) / peak;
                    r = (r * rcm_pkg::PEAK_LIMIT) / peak;
                end
                l = clamp_track((l * pct) / rcm_pkg::PCT_SCALE);
                r = clamp_track((r * pct) / rcm_pkg::PCT_SCALE);
                o.left  = l[rcm_pkg::STICK_W-1:0];
                o.right = r[rcm_pkg::STICK_W-1:0];
            end
            if (!latch_q && o.laser)
                o.fire = t.fire > fire_thr;
        end
        o.latch = latch_q;
        return o;
    endfunction

    function automatic logic [rcm_pkg::US_W-1:0] pulse_us(logic high);
        return high ? rcm_pkg::US_W'($urandom_range(2047, 1800))
                    : rcm_pkg::US_W'($urandom_range(1200, 950));
    endfunction

    function automatic tick_t random_tick();
        tick_t t;
        if ($urandom_range(99) < 25)
        begin
            // noise: every bit free, sticks beyond the normal range included
            t.link  = ($urandom_range(9) != 0);
            t.estop = rcm_pkg::US_W'($urandom);
            t.laser = rcm_pkg::US_W'($urandom);
            t.mode  = rcm_pkg::US_W'($urandom);
            t.speed = rcm_pkg::US_W'($urandom);
            t.fire  = rcm_pkg::US_W'($urandom);
            t.thr   = rcm_pkg::STICK_W'($urandom);
            t.steer = rcm_pkg::STICK_W'($urandom);
        end
        else
        begin
            t.link  = ($urandom_range(49) != 0);
            t.estop = pulse_us($urandom_range(99) < 10);
            t.laser = pulse_us($urandom_range(99) < 10);
            t.mode  = pulse_us($urandom_range(99) < 15);
            t.speed = rcm_pkg::US_W'($urandom_range(2047, 1000));
            t.fire  = pulse_us($urandom_range(1) != 0);
            t.thr   = rcm_pkg::STICK_W'(int'($urandom_range(2000)) - 1000);
            t.steer = rcm_pkg::STICK_W'(int'($urandom_range(2000)) - 1000);
        end
        return t;
    endfunction

    task automatic add_tick(int link, int estop, int laser, int mode, int speed, int fire,
                            int thr, int steer);
        tick_t t;
        t.link  = (link != 0);
        t.estop = rcm_pkg::US_W'(estop);
        t.laser = rcm_pkg::US_W'(laser);
        t.mode  = rcm_pkg::US_W'(mode);
        t.speed = rcm_pkg::US_W'(speed);
        t.fire  = rcm_pkg::US_W'(fire);
        t.thr   = rcm_pkg::STICK_W'(thr);
        t.steer = rcm_pkg::STICK_W'(steer);
        ticks_waiting.push_back(t);
    endtask

    task automatic add_random(int n);
        repeat (n)
            ticks_waiting.push_back(random_tick());
    endtask

    task automatic write_reg(rcm_pkg::cfg_idx_t idx, logic [rcm_pkg::CFG_DAT_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            rcm_pkg::CFG_AUTO_THR:   auto_thr  = data;
            rcm_pkg::CFG_LASER_THR:  laser_thr = data;
            rcm_pkg::CFG_ESTOP_THR:  estop_thr = data;
            rcm_pkg::CFG_FIRE_THR:   fire_thr  = data;
            rcm_pkg::CFG_TURN_GAIN:  turn_gain = data[rcm_pkg::PCT_W-1:0];
            rcm_pkg::CFG_SPEED_LOW:  lim_low   = data[rcm_pkg::PCT_W-1:0];
            rcm_pkg::CFG_SPEED_MID:  lim_mid   = data[rcm_pkg::PCT_W-1:0];
            rcm_pkg::CFG_SPEED_HIGH: lim_high  = data[rcm_pkg::PCT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_regs(int a, int l, int e, int f, int g, int lo, int mi, int hi);
        write_reg(rcm_pkg::CFG_AUTO_THR, rcm_pkg::CFG_DAT_W'(a));
        write_reg(rcm_pkg::CFG_LASER_THR, rcm_pkg::CFG_DAT_W'(l));
        write_reg(rcm_pkg::CFG_ESTOP_THR, rcm_pkg::CFG_DAT_W'(e));
        write_reg(rcm_pkg::CFG_FIRE_THR, rcm_pkg::CFG_DAT_W'(f));
        write_reg(rcm_pkg::CFG_TURN_GAIN, rcm_pkg::CFG_DAT_W'(g));
        write_reg(rcm_pkg::CFG_SPEED_LOW, rcm_pkg::CFG_DAT_W'(lo));
        write_reg(rcm_pkg::CFG_SPEED_MID, rcm_pkg::CFG_DAT_W'(mi));
        write_reg(rcm_pkg::CFG_SPEED_HIGH, rcm_pkg::CFG_DAT_W'(hi));
    endtask

    task automatic drain();
        do
            @(negedge clk);
        while (ticks_waiting.size() != 0 || in_valid || due_cmds.size() != 0);
    endtask

    task automatic check_field(string what, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endtask

    // driver: advance to the next pending tick once the current one transfers
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            due_cmds.push_back(mix_tick(cur_tick));
        if (!in_valid || in_ready)
        begin
            if (ticks_waiting.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                cur_tick = ticks_waiting.pop_front();
                in_valid         <= 1'b1;
                link_ok          <= cur_tick.link;
                estop_channel_us <= cur_tick.estop;
                laser_channel_us <= cur_tick.laser;
                mode_channel_us  <= cur_tick.mode;
                speed_channel_us <= cur_tick.speed;
                fire_channel_us  <= cur_tick.fire;
                throttle_norm    <= cur_tick.thr;
                steer_norm       <= cur_tick.steer;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk)
    begin
        track_cmd_t want;
        if (out_valid && out_ready)
        begin
            if (due_cmds.size() == 0)
            begin
                errors++;
                $display("%0t: result with nothing expected, expected none, actual %0d/%0d",
                         $time, left_speed, right_speed);
            end
            else
            begin
                want = due_cmds.pop_front();
                check_field("left_speed", 32'(want.left), 32'(left_speed));
                check_field("right_speed", 32'(want.right), 32'(right_speed));
                check_field("motor_enable", 32'(want.en), 32'(motor_enable));
                check_field("fire_out", 32'(want.fire), 32'(fire_out));
                check_field("laser_active", 32'(want.laser), 32'(laser_active));
                check_field("auto_active", 32'(want.autom), 32'(auto_active));
                check_field("estop_latched", 32'(want.latch), 32'(estop_latched));
            end
        end
        // hold off for a long stretch so the block backs up into its input
        if (hold_req && hold_cnt < HOLD_LEN)
        begin
            out_ready <= 1'b0;
            hold_cnt++;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
        begin
            quiet <= quiet + 1;
            if (quiet >= QUIET_MAX)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset defaults: field extremes, speed bands, modes and the stop latch
        add_tick(0, 0, 0, 0, 0, 0, 0, 0);
        add_tick(1, 1000, 1000, 1000, 2047, 1000, 1000, 0);
        add_tick(1, 1000, 1000, 1000, 1500, 1000, -1000, 1000);
        add_tick(1, 1000, 1000, 1000, 2047, 1000, 1000, 1000);
        add_tick(1, 1000, 1000, 1000, 2047, 1000, -1024, -1024);
        add_tick(1, 1000, 1000, 1000, 2047, 1000, 1023, 1023);
        add_tick(1, 1000, 1000, 1000, 1700, 1000, 500, -300);
        add_tick(1, 1000, 1000, 1000, 1701, 1000, 500, -300);
        add_tick(1, 1000, 1000, 1000, 1300, 1000, -700, 400);
        add_tick(1, 1000, 1000, 1000, 1301, 1000, -700, 400);
        add_tick(1, 1000, 2047, 1000, 1000, 2047, 800, 0);
        add_tick(1, 1000, 1800, 1000, 1000, 1700, 800, 0);
        add_tick(1, 1000, 1701, 1000, 1000, 1701, 0, 0);
        add_tick(1, 1000, 1000, 2047, 1000, 2047, 800, 0);
        add_tick(1, 1000, 2047, 2047, 1000, 2047, 800, 0);
        add_tick(1, 1500, 1000, 1000, 1000, 1000, 300, 300);
        add_tick(1, 2047, 1000, 1000, 2047, 1000, 900, 0);
        add_tick(1, 2047, 1000, 2047, 2047, 1000, 900, 0);
        add_tick(1, 1000, 1000, 2047, 2047, 1000, 900, 0);
        add_tick(0, 2047, 1000, 1000, 2047, 1000, 900, 0);
        add_tick(1, 2047, 2047, 1000, 1000, 2047, 900, 0);
        add_tick(1, 1000, 1000, 1000, 2047, 1000, 600, 200);
        add_tick(1, 0, 0, 0, 0, 0, -1000, -1000);
        add_random(100);
        drain();

        // nothing ever above threshold, full gain and speed
        load_regs(2047, 2047, 2047, 2047, 100, 100, 100, 100);
        tx_idle_pct = 69;
        add_random(76);
        drain();

        // turn gain and middle speed percent at their top, upper data bits set to check masking
        load_regs(1500, 1700, 1500, 1700, 'h7FF, 'h780, 'h7FF, 50);
        tx_idle_pct = 0;
        rx_idle_pct = 69;
        add_random(76);
        drain();

        load_regs(0, 0, 0, 0, 0, 0, 1, 2);
        tx_idle_pct = 34;
        rx_idle_pct = 34;
        add_random(76);
        drain();

        load_regs(int'(rcm_pkg::AUTO_THR_RST), int'(rcm_pkg::LASER_THR_RST),
                  int'(rcm_pkg::ESTOP_THR_RST), int'(rcm_pkg::FIRE_THR_RST),
                  int'(rcm_pkg::TURN_GAIN_RST), int'(rcm_pkg::SPEED_LOW_RST),
                  int'(rcm_pkg::SPEED_MID_RST), int'(rcm_pkg::SPEED_HIGH_RST));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
        add_random(76);
        drain();

        load_regs($urandom_range(2000, 1000), $urandom_range(2000, 1000),
                  $urandom_range(2000, 1000), $urandom_range(2000, 1000),
                  $urandom_range(127), $urandom_range(127),
                  $urandom_range(127), $urandom_range(127));
        tx_idle_pct = 34;
        rx_idle_pct = 34;
        add_random(76);
        drain();

        repeat (DRAIN_GAP) @(posedge clk);
        if (errors == 0 && due_cmds.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

FILE: filelist.f
src/rcm_pkg.sv
src/rcm_ctrl.sv
src/rcm_dp.sv
src/rc_mode_estop_and_skid_steer_mixer_unit.sv
dv/tb_rc_mode_estop_and_skid_steer_mixer_unit.sv
